FILE: design/assert_macros.svh
// Shared assertion macros for the keyed stack design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ksp_pkg.sv
package ksp_pkg;

    localparam int DEPTH   = 128;
    localparam int KEY_W   = 56;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = $clog2(DEPTH);
    localparam int GRP_SZ  = 8;
    localparam int LO_W    = 3;
    localparam int GRP_N   = (DEPTH + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_IW  = (GRP_N > 1) ? $clog2(GRP_N) : 1;
    localparam int ABOVE_W = 7;
    localparam int OCC_W   = 8;
    localparam int STAT_W  = 2;

    typedef logic [KEY_W-1:0] t_key;

    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_PUSHED    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_REMOVED   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

    // per-cell controls from the sequencer
    typedef struct packed {
        logic cmp_en;   // capture compare result
        logic live;     // cell lies below the top of stack
        logic load;     // take the pushed key
        logic shift;    // take the key of the cell above
    } t_cell_ctl;

endpackage

FILE: design/ksp_cell.sv
module ksp_cell (
    input  logic               i_clk,
    input  ksp_pkg::t_cell_ctl i_ctl,
    input  ksp_pkg::t_key      i_bcast_key,
    input  ksp_pkg::t_key      i_up_key,
    output ksp_pkg::t_key      o_key,
    output logic               o_match
);
    import ksp_pkg::*;

    t_key r_key;
    logic r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= i_bcast_key;
        end else if (i_ctl.shift) begin
            r_key <= i_up_key;
        end
        if (i_ctl.cmp_en) begin
            r_match <= i_ctl.live && (r_key == i_bcast_key);
        end
    end

    assign o_key   = r_key;
    assign o_match = r_match;

endmodule

FILE: design/ksp_locate.sv
module ksp_locate (
    input  logic                      i_clk,
    input  logic                      i_grp_en,
    input  logic [ksp_pkg::DEPTH-1:0] i_match,
    output logic                      o_found,
    output logic [ksp_pkg::POS_W-1:0] o_pos
);
    import ksp_pkg::*;

    logic [GRP_N*GRP_SZ-1:0] w_pad;
    logic [GRP_N-1:0]        w_gany;
    logic [GRP_IW-1:0]       w_top_grp;
    logic [GRP_N-1:0]        r_gany;
    logic [GRP_IW-1:0]       r_top_grp;
    logic                    r_found;
    logic [GRP_SZ-1:0]       w_sel;
    logic [LO_W-1:0]         w_lo;
    logic [GRP_IW+LO_W-1:0]  w_pos_wide;

    assign w_pad = (GRP_N*GRP_SZ)'(i_match);

    // stage 1: which group of eight holds the topmost match
    always_comb begin
        w_top_grp = '0;
        for (int g = 0; g < GRP_N; g++) begin
            w_gany[g] = |w_pad[g*GRP_SZ +: GRP_SZ];
            if (w_gany[g]) begin
                w_top_grp = GRP_IW'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_en) begin
            r_gany    <= w_gany;
            r_top_grp <= w_top_grp;
            r_found   <= |w_gany;
        end
    end

    // stage 2: topmost match inside that group
    assign w_sel = w_pad[r_top_grp*GRP_SZ +: GRP_SZ];

    always_comb begin
        w_lo = '0;
        for (int k = 0; k < GRP_SZ; k++) begin
            if (w_sel[k]) begin
                w_lo = LO_W'(k);
            end
        end
    end

    assign w_pos_wide = {r_top_grp, w_lo};
    assign o_pos      = POS_W'(w_pos_wide);
    assign o_found    = r_found && r_gany[r_top_grp];

endmodule

FILE: design/keyed_stack_push_remove_unit.sv
// Channel  | Ports     | Payload (low bit first)
// request  | s_axis_*  | tuser: req_type[0]; tdata: key[55:0]
// result   | m_axis_*  | tuser: status[1:0]; tdata: entries_above[6:0],
//          |           |        occupancy[14:7], zero[15]
//
// A push goes through accept and update; a remove goes through accept,
// compare in every cell, group search, locate + shift. The longer remove path
// is set by the registered compare and the two-level topmost-match search.
// Reset (synchronous, active low) empties the stack; cell keys are not
// cleared. A request is accepted while a result still waits; the update
// cycle holds until the output register is free.
module keyed_stack_push_remove_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // key[55:0]
    input  logic [0:0]  s_axis_tuser,   // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // entries_above[6:0], occupancy[14:7], 0[15]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import ksp_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_GRP, S_FIN} t_state;

    t_state              r_state;
    logic                r_type;       // latched request kind
    t_key                r_key;        // latched request key, broadcast to cells
    logic [CNT_W-1:0]    r_count;      // entries held
    logic                r_out_valid;
    logic [STAT_W-1:0]   r_status;
    logic [ABOVE_W-1:0]  r_above;
    logic [OCC_W-1:0]    r_occ;

    logic                w_in_acc;
    logic                w_fin_go;     // update cycle may complete
    logic                w_full;
    logic                w_found;
    logic [POS_W-1:0]    w_pos;
    logic [DEPTH-1:0]    w_match;
    t_key                w_cell_key [DEPTH];
    t_cell_ctl           w_ctl      [DEPTH];
    logic [CNT_W-1:0]    w_above_cnt;
    logic [31:0]         w_above32;
    logic [31:0]         w_occ_inc32;
    logic [31:0]         w_occ_dec32;
    logic [31:0]         w_occ_same32;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_fin_go      = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);
    assign w_full        = (r_count >= CNT_W'(DEPTH));

    // the row of cells: slot 0 is the bottom
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign w_ctl[i].cmp_en = (r_state == S_CMP);
        assign w_ctl[i].live   = (CNT_W'(i) < r_count);
        assign w_ctl[i].load   = w_fin_go && (r_type == REQ_PUSH) && !w_full &&
                                 (CNT_W'(i) == r_count);
        assign w_ctl[i].shift  = w_fin_go && (r_type == REQ_REMOVE) && w_found &&
                                 (POS_W'(i) >= w_pos);

        ksp_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl[i]),
            .i_bcast_key (r_key),
            .i_up_key    (w_cell_key[(i == DEPTH - 1) ? i : i + 1]),
            .o_key       (w_cell_key[i]),
            .o_match     (w_match[i])
        );
    end

    ksp_locate u_locate (
        .i_clk    (i_clk),
        .i_grp_en (r_state == S_GRP),
        .i_match  (w_match),
        .o_found  (w_found),
        .o_pos    (w_pos)
    );

    // entries above the hit: count - 1 - pos
    assign w_above_cnt  = CNT_W'(r_count - CNT_W'(1) - CNT_W'(w_pos));
    assign w_above32    = 32'(w_above_cnt);
    assign w_occ_inc32  = 32'(r_count) + 32'd1;
    assign w_occ_dec32  = 32'(r_count) - 32'd1;
    assign w_occ_same32 = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a result leaves; a new one posted this cycle takes its place
            if (m_axis_tready && !w_fin_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_type  <= s_axis_tuser[0];
                        r_key   <= s_axis_tdata;
                        r_state <= (s_axis_tuser[0] == REQ_PUSH) ? S_FIN : S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_GRP;
                end
                S_GRP: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                        if (r_type == REQ_PUSH) begin
                            r_above <= '0;
                            if (w_full) begin
                                r_status <= ST_FULL;
                                r_occ    <= w_occ_same32[OCC_W-1:0];
                            end else begin
                                r_status <= ST_PUSHED;
                                r_count  <= CNT_W'(w_occ_inc32);
                                r_occ    <= w_occ_inc32[OCC_W-1:0];
                            end
                        end else if (w_found) begin
                            r_status <= ST_REMOVED;
                            r_count  <= CNT_W'(w_occ_dec32);
                            r_occ    <= w_occ_dec32[OCC_W-1:0];
                            r_above  <= w_above32[ABOVE_W-1:0];
                        end else begin
                            r_status <= ST_NOT_FOUND;
                            r_occ    <= w_occ_same32[OCC_W-1:0];
                            r_above  <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {1'b0, r_occ, r_above};

    `KSP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "stack count exceeds depth")
    `KSP_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, w_in_acc, r_state != S_IDLE,
        "request accepted but sequencer stayed idle")
    `KSP_ASSERT_NEXT(a_remove_drops_one, i_clk, i_rst_n,
        w_fin_go && (r_type == REQ_REMOVE) && w_found,
        r_count == CNT_W'($past(r_count) - CNT_W'(1)),
        "successful remove did not drop count by one")
    `KSP_ASSERT_NEXT(a_fin_yields_result, i_clk, i_rst_n, w_fin_go,
        r_out_valid && (r_state == S_IDLE),
        "update cycle did not post a result")

endmodule
